### rtl/core/hfp_pkg.sv
// Shared types, constants and helpers for the HTTP header field parser.
`default_nettype none

package hfp_pkg;

    // Largest number of trailing blanks held back inside a name or a value.
    localparam int HELD_MAX   = 32;
    localparam int HELD_CNT_W = $clog2(HELD_MAX + 1);
    localparam int HELD_IDX_W = (HELD_MAX > 1) ? $clog2(HELD_MAX) : 1;

    // Depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_IDX_W + 1;

    // Characters of the grammar.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_PIPE  = 8'h7C;

    typedef enum logic [3:0] {
        PH_NAME_START = 4'd0,
        PH_NAME       = 4'd1,
        PH_LOWS       = 4'd2,
        PH_VALUE      = 4'd3,
        PH_CR         = 4'd4,
        PH_CRLF       = 4'd5,
        PH_CRLFCR     = 4'd6,
        PH_COMPLETE   = 4'd7,
        PH_FAILED     = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        K_NAME      = 3'd0,
        K_VALUE     = 3'd1,
        K_FIELD_END = 3'd2,
        K_COMPLETE  = 3'd3,
        K_FAIL      = 3'd4
    } kind_t;

    // One command: a run of held blanks, then one or two plain results.
    typedef struct packed {
        logic [HELD_CNT_W-1:0] flush_cnt;
        logic                  flush_val;
        logic [HELD_MAX-1:0]   blanks;
        kind_t                 r0_kind;
        logic [7:0]            r0_data;
        logic                  r1_valid;
        kind_t                 r1_kind;
        logic [7:0]            r1_data;
    } cmd_t;

    // Token characters of a field name.
    function automatic logic is_token(input logic [7:0] c);
        logic ok;
        ok = 1'b0;
        if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h30 && c <= 8'h39))
        begin
            ok = 1'b1;
        end
        else
        begin
            case (c)
                CH_BANG, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h60, 8'h2A,
                8'h2B, 8'h2D, 8'h2E, 8'h5E, 8'h5F, CH_PIPE, CH_TILDE:
                    ok = 1'b1;
                default:
                    ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

### rtl/core/http_header_field_parser.sv
// Top level of the HTTP header field parser: front end, command queue and back end.
// The parser takes one header byte per transaction on the push side and gives tagged
// results on the pop side: name bytes, value bytes, field end, block complete or
// parse failed, with run_last marking the final result of each byte. A byte is
// taken whenever the four-entry command queue has room; the back end gives one result
// per cycle while pop is held, so a byte that causes k results holds the back end until
// all k are popped (up to 33 when 32 held blanks are released with the next byte).
// Bytes that cause no result put nothing in the back end. A byte with block_end set
// ends the block, and the next byte starts a new one.
`default_nettype none

module http_header_field_parser
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] byte_value,
    input  wire logic       block_end,
    output logic            empty,
    input  wire logic       pop,
    output logic [2:0]      kind,
    output logic [7:0]      data_byte,
    output logic            run_last
);
    import hfp_pkg::*;

    cmd_t  front_cmd;
    cmd_t  head_cmd;
    logic  front_enq;
    logic  head_done;
    kind_t out_kind;

    // Front end sees a byte only when the queue can take its command.
    hfp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (push && !full),
        .byte_value (byte_value),
        .block_end  (block_end),
        .cmd        (front_cmd),
        .enq        (front_enq)
    );

    hfp_cmd_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_enq),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (head_done),
        .rd_data (head_cmd),
        .empty   (empty)
    );

    hfp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .head_empty (empty),
        .head_done  (head_done),
        .pop        (pop),
        .kind       (out_kind),
        .data_byte  (data_byte),
        .run_last   (run_last)
    );

    assign kind = 3'(out_kind);

endmodule

`default_nettype wire

### rtl/core/hfp_front.sv
// Front end: classifies each header byte, tracks parse state and builds commands.
`default_nettype none

module hfp_front
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic [7:0]   byte_value,
    input  wire logic         block_end,
    output hfp_pkg::cmd_t     cmd,
    output logic              enq
);
    import hfp_pkg::*;

    phase_t                phase_reg, phase_next;
    logic                  first_reg, first_next;
    logic [HELD_CNT_W-1:0] names_reg, names_next;
    logic [HELD_CNT_W-1:0] vcnt_reg, vcnt_next;
    logic [HELD_MAX-1:0]   blanks_reg, blanks_next;
    logic                  emit0;
    logic                  fail;
    logic                  tok;
    logic                  blank;

    assign tok   = is_token(byte_value);
    assign blank = (byte_value == CH_SPACE) || (byte_value == CH_TAB);

    // Next state and the command caused by the current byte.
    always_comb
    begin
        phase_next  = phase_reg;
        first_next  = first_reg;
        names_next  = names_reg;
        vcnt_next   = vcnt_reg;
        blanks_next = blanks_reg;
        emit0       = 1'b0;
        fail        = 1'b0;
        cmd         = '0;
        cmd.blanks  = blanks_reg;
        if (in_valid)
        begin
            unique case (phase_reg)
                PH_NAME_START:
                begin
                    if (tok)
                    begin
                        emit0       = 1'b1;
                        cmd.r0_kind = K_NAME;
                        cmd.r0_data = byte_value;
                        phase_next  = PH_NAME;
                    end
                    else if (first_reg && byte_value == CH_CR)
                        phase_next = PH_CRLFCR;
                    else
                        fail = 1'b1;
                end
                PH_NAME:
                begin
                    if (tok)
                    begin
                        emit0         = 1'b1;
                        cmd.flush_cnt = names_reg;
                        cmd.flush_val = 1'b0;
                        cmd.r0_kind   = K_NAME;
                        cmd.r0_data   = byte_value;
                        names_next    = '0;
                    end
                    else if (byte_value == CH_SPACE)
                    begin
                        if (names_reg >= HELD_CNT_W'(HELD_MAX))
                            fail = 1'b1;
                        else
                            names_next = names_reg + HELD_CNT_W'(1);
                    end
                    else if (byte_value == CH_COLON)
                    begin
                        names_next = '0;
                        phase_next = PH_LOWS;
                    end
                    else
                        fail = 1'b1;
                end
                PH_LOWS:
                begin
                    if (blank)
                    begin
                        phase_next = PH_LOWS;
                    end
                    else if (byte_value == CH_CR)
                        phase_next = PH_CR;
                    else
                    begin
                        emit0       = 1'b1;
                        cmd.r0_kind = K_VALUE;
                        cmd.r0_data = byte_value;
                        phase_next  = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    if (byte_value == CH_CR)
                        phase_next = PH_CR;
                    else if (blank)
                    begin
                        if (vcnt_reg >= HELD_CNT_W'(HELD_MAX))
                            fail = 1'b1;
                        else
                        begin
                            blanks_next[vcnt_reg[HELD_IDX_W-1:0]] = (byte_value == CH_TAB);
                            vcnt_next = vcnt_reg + HELD_CNT_W'(1);
                        end
                    end
                    else
                    begin
                        emit0         = 1'b1;
                        cmd.flush_cnt = vcnt_reg;
                        cmd.flush_val = 1'b1;
                        cmd.r0_kind   = K_VALUE;
                        cmd.r0_data   = byte_value;
                        vcnt_next     = '0;
                    end
                end
                PH_CR:
                begin
                    if (byte_value == CH_LF)
                        phase_next = PH_CRLF;
                    else
                        fail = 1'b1;
                end
                PH_CRLF:
                begin
                    if (blank)
                    begin
                        // A continuation line: the blank is held like any other.
                        if (vcnt_reg >= HELD_CNT_W'(HELD_MAX))
                            fail = 1'b1;
                        else
                        begin
                            blanks_next[vcnt_reg[HELD_IDX_W-1:0]] = (byte_value == CH_TAB);
                            vcnt_next  = vcnt_reg + HELD_CNT_W'(1);
                            phase_next = PH_VALUE;
                        end
                    end
                    else
                    begin
                        emit0       = 1'b1;
                        cmd.r0_kind = K_FIELD_END;
                        vcnt_next   = '0;
                        names_next  = '0;
                        if (byte_value == CH_CR)
                            phase_next = PH_CRLFCR;
                        else if (tok)
                        begin
                            cmd.r1_valid = 1'b1;
                            cmd.r1_kind  = K_NAME;
                            cmd.r1_data  = byte_value;
                            phase_next   = PH_NAME;
                        end
                        else
                            fail = 1'b1;
                    end
                end
                PH_CRLFCR:
                begin
                    if (byte_value == CH_LF)
                    begin
                        emit0       = 1'b1;
                        cmd.r0_kind = K_COMPLETE;
                        phase_next  = PH_COMPLETE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            // A failure follows whatever the byte already produced.
            if (fail)
            begin
                if (emit0)
                begin
                    cmd.r1_valid = 1'b1;
                    cmd.r1_kind  = K_FAIL;
                    cmd.r1_data  = '0;
                end
                else
                begin
                    emit0       = 1'b1;
                    cmd.r0_kind = K_FAIL;
                    cmd.r0_data = '0;
                end
                phase_next = PH_FAILED;
            end
            first_next = 1'b0;

            // The final byte of an unfinished block yields a single failure.
            if (block_end)
            begin
                if (phase_next != PH_COMPLETE && phase_next != PH_FAILED)
                begin
                    emit0         = 1'b1;
                    cmd.flush_cnt = '0;
                    cmd.r0_kind   = K_FAIL;
                    cmd.r0_data   = '0;
                    cmd.r1_valid  = 1'b0;
                end
                phase_next = PH_NAME_START;
                first_next = 1'b1;
                names_next = '0;
                vcnt_next  = '0;
            end
        end
    end

    assign enq = in_valid && emit0;

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NAME_START;
            first_reg <= 1'b1;
            names_reg <= '0;
            vcnt_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            first_reg <= first_next;
            names_reg <= names_next;
            vcnt_reg  <= vcnt_next;
        end
    end

    // Held value blanks: only entries below the count are ever read.
    always_ff @(posedge clk)
    begin
        blanks_reg <= blanks_next;
    end

`ifndef SYNTHESIS
    // Held counts never pass the buffer size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (names_reg <= HELD_CNT_W'(HELD_MAX)) && (vcnt_reg <= HELD_CNT_W'(HELD_MAX)))
        else $error("held blank count beyond buffer size");

    // A finished block produces nothing until its final byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !block_end && (phase_reg == PH_COMPLETE || phase_reg == PH_FAILED))
        |-> !enq)
        else $error("command issued after block finished");
`endif

endmodule

`default_nettype wire

### rtl/core/hfp_cmd_queue.sv
// Short command queue that decouples the front end from the result expander.
`default_nettype none

module hfp_cmd_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire hfp_pkg::cmd_t wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output hfp_pkg::cmd_t      rd_data,
    output logic               empty
);
    import hfp_pkg::*;

    cmd_t                   store_reg [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_wr;
    logic                   do_rd;

    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_IDX_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_IDX_W'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            store_reg[wr_ptr_reg] <= wr_data;
    end

`ifndef SYNTHESIS
    // The fill count stays within the depth and tracks the pointers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH)) &&
        ((count_reg == '0 || count_reg == QUEUE_CNT_W'(QUEUE_DEPTH)) ==
         (wr_ptr_reg == rd_ptr_reg)))
        else $error("queue count out of step with pointers");
`endif

endmodule

`default_nettype wire

### rtl/core/hfp_back.sv
// Back end: expands each command into its results, one per cycle while pop is high.
`default_nettype none

module hfp_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hfp_pkg::cmd_t head,
    input  wire logic          head_empty,
    output logic               head_done,
    input  wire logic          pop,
    output hfp_pkg::kind_t     kind,
    output logic [7:0]         data_byte,
    output logic               run_last
);
    import hfp_pkg::*;

    logic [HELD_CNT_W-1:0] step_reg, step_next;
    logic                  in_flush;
    logic                  at_r0;
    logic                  take;

    assign in_flush = (step_reg < head.flush_cnt);
    assign at_r0    = (step_reg == head.flush_cnt);
    assign take     = pop && !head_empty;

    // Select the current result of the head command.
    always_comb
    begin
        priority if (in_flush)
        begin
            kind      = head.flush_val ? K_VALUE : K_NAME;
            data_byte = (head.flush_val && head.blanks[step_reg[HELD_IDX_W-1:0]])
                      ? CH_TAB : CH_SPACE;
            run_last  = 1'b0;
        end
        else if (at_r0)
        begin
            kind      = head.r0_kind;
            data_byte = head.r0_data;
            run_last  = !head.r1_valid;
        end
        else
        begin
            kind      = head.r1_kind;
            data_byte = head.r1_data;
            run_last  = 1'b1;
        end
    end

    assign head_done = take && run_last;

    // Step through the command as results are taken.
    always_comb
    begin
        step_next = step_reg;
        if (take)
            step_next = run_last ? '0 : step_reg + HELD_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

`ifndef SYNTHESIS
    // The step never runs past the second plain result of the head command.
    assert property (@(posedge clk) disable iff (!rst_n)
        !head_empty |-> (step_reg <= head.flush_cnt + HELD_CNT_W'(1)))
        else $error("result step beyond command end");

    // A new command always starts at its first result.
    assert property (@(posedge clk) disable iff (!rst_n)
        head_done |=> (step_reg == '0))
        else $error("step not cleared after command");
`endif

endmodule

`default_nettype wire

### verif/http_header_field_parser_tb.sv
// Self-checking testbench for the HTTP header field parser, with its own result predictor.
`timescale 1ns / 100ps

import hfp_pkg::*;

// One expected result transaction on the pop side.
typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
} parse_result_t;

// Tracks the parser state, predicts the results of each accepted byte and checks
// every popped result against the oldest prediction.
class field_result_board;

    phase_t        phase;
    bit            first_byte;
    int unsigned   name_spaces;
    bit            value_tabs[HELD_MAX];
    int unsigned   value_count;
    parse_result_t byte_results[$];
    parse_result_t results_due[$];
    int            errors;

    function new();
        errors = 0;
        clear_state();
    endfunction

    function void clear_state();
        phase       = PH_NAME_START;
        first_byte  = 1'b1;
        name_spaces = 0;
        value_count = 0;
    endfunction

    function int pending();
        return results_due.size();
    endfunction

    // Letters, digits and the punctuation that a field name may hold.
    function bit token_char(logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if ((folded >= 8'h61 && folded <= 8'h7A) || (c >= 8'h30 && c <= 8'h39))
            return 1'b1;
        case (c)
            // ! # $ % & ' * + - . ^ _ ` | ~
            CH_BANG, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D,
            8'h2E, 8'h5E, 8'h5F, 8'h60, CH_PIPE, CH_TILDE:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function void add_result(kind_t k, logic [7:0] d);
        parse_result_t r;
        r.kind = k;
        r.data = d;
        r.last = 1'b0;
        byte_results = {byte_results, r};
    endfunction

    // Holds one trailing value blank; returns 0 when the store is already full.
    function bit hold_value_blank(logic [7:0] b);
        if (value_count >= HELD_MAX)
            return 1'b0;
        value_tabs[value_count] = (b == CH_TAB);
        value_count++;
        return 1'b1;
    endfunction

    function void release_value_blanks();
        for (int i = 0; i < value_count; i++)
            add_result(K_VALUE, value_tabs[i] ? CH_TAB : CH_SPACE);
        value_count = 0;
    endfunction

    // Predicts the results of one accepted byte. Returns 1 if the byte was
    // parsed, 0 if it fell after a completed or failed block and was ignored.
    function bit note_byte(logic [7:0] b, logic last);
        bit            fail;
        bit            parsed;
        bit            blank;
        fail   = 1'b0;
        parsed = (phase != PH_COMPLETE) && (phase != PH_FAILED);
        blank  = (b == CH_SPACE) || (b == CH_TAB);
        byte_results.delete();

        case (phase)
            PH_NAME_START:
            begin
                if (token_char(b))
                begin
                    add_result(K_NAME, b);
                    phase = PH_NAME;
                end
                else if (first_byte && b == CH_CR)
                    phase = PH_CRLFCR;
                else
                    fail = 1'b1;
            end
            PH_NAME:
            begin
                if (token_char(b))
                begin
                    repeat (name_spaces) add_result(K_NAME, CH_SPACE);
                    name_spaces = 0;
                    add_result(K_NAME, b);
                end
                else if (b == CH_SPACE)
                begin
                    if (name_spaces >= HELD_MAX)
                        fail = 1'b1;
                    else
                        name_spaces++;
                end
                else if (b == CH_COLON)
                begin
                    name_spaces = 0;
                    phase = PH_LOWS;
                end
                else
                    fail = 1'b1;
            end
            PH_LOWS:
            begin
                // Blanks ahead of a value are dropped.
                if (b == CH_CR)
                    phase = PH_CR;
                else if (!blank)
                begin
                    add_result(K_VALUE, b);
                    phase = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                if (b == CH_CR)
                    phase = PH_CR;
                else if (blank)
                    fail = !hold_value_blank(b);
                else
                begin
                    release_value_blanks();
                    add_result(K_VALUE, b);
                end
            end
            PH_CR:
            begin
                if (b == CH_LF)
                    phase = PH_CRLF;
                else
                    fail = 1'b1;
            end
            PH_CRLF:
            begin
                if (blank)
                begin
                    // A continuation line keeps adding to the same value.
                    if (!hold_value_blank(b))
                        fail = 1'b1;
                    else
                        phase = PH_VALUE;
                end
                else
                begin
                    add_result(K_FIELD_END, 8'h00);
                    value_count = 0;
                    name_spaces = 0;
                    if (b == CH_CR)
                        phase = PH_CRLFCR;
                    else if (token_char(b))
                    begin
                        add_result(K_NAME, b);
                        phase = PH_NAME;
                    end
                    else
                        fail = 1'b1;
                end
            end
            PH_CRLFCR:
            begin
                // Only LF ends the block; anything else is ignored.
                if (b == CH_LF)
                begin
                    add_result(K_COMPLETE, 8'h00);
                    phase = PH_COMPLETE;
                end
            end
            default:
            begin
            end
        endcase

        if (fail)
        begin
            add_result(K_FAIL, 8'h00);
            phase = PH_FAILED;
        end
        first_byte = 1'b0;

        // The final byte of an unfinished block gives a lone failure.
        if (last)
        begin
            if (phase != PH_COMPLETE && phase != PH_FAILED)
            begin
                byte_results.delete();
                add_result(K_FAIL, 8'h00);
            end
            clear_state();
        end

        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].last = 1'b1;
        results_due = {results_due, byte_results};
        return parsed;
    endfunction

    // Compares one popped result with the oldest prediction.
    function void check_result(logic [2:0] k, logic [7:0] d, logic l);
        parse_result_t want;
        if (results_due.size() == 0)
        begin
            $error("unexpected result: kind %0d data 0x%02h run_last %0b", k, d, l);
            errors++;
            return;
        end
        want = results_due.pop_front();
        if (k !== want.kind)
        begin
            $error("kind: expected %0d, actual %0d", want.kind, k);
            errors++;
        end
        if (d !== want.data)
        begin
            $error("data_byte: expected 0x%02h, actual 0x%02h", want.data, d);
            errors++;
        end
        if (l !== want.last)
        begin
            $error("run_last: expected %0b, actual %0b", want.last, l);
            errors++;
        end
    endfunction

endclass

module http_header_field_parser_tb;

    localparam int RANDOM_ITEMS = 180;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 100;
    // Idle and stall percentages for the four traffic phases.
    localparam int SEND_IDLE[4]  = '{0, 53, 0, 22};
    localparam int RECV_STALL[4] = '{0, 0, 53, 22};

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] byte_value;
    logic       block_end;
    logic       empty;
    logic       pop;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       run_last;

    field_result_board board;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                live_items;
    int                cycle_count;
    logic [7:0]        block_bytes[$];

    http_header_field_parser dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .byte_value (byte_value),
        .block_end  (block_end),
        .empty      (empty),
        .pop        (pop),
        .kind       (kind),
        .data_byte  (data_byte),
        .run_last   (run_last)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the total run length.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= LIMIT_CYCLES)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Pushes one byte, idling first at random. The handshake is sampled at the
    // falling edge, where every signal is settled for the next rising edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        byte_value <= b;
        block_end  <= last;
        do
        begin
            @(negedge clk);
            taken = (full === 1'b0);
            if (taken && board.note_byte(b, last))
                live_items++;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic send_text(input string s, input bit last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last && (i == s.len() - 1));
    endtask

    // Lowers push and waits until every predicted result has been popped.
    task automatic drain_results();
        push <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    function automatic logic [7:0] random_token();
        logic [7:0] c;
        do
            c = 8'($urandom_range(33, 126));
        while (!board.token_char(c));
        return c;
    endfunction

    // Any byte that a value may carry: mostly printable, sometimes any code.
    function automatic logic [7:0] random_value_byte();
        logic [7:0] c;
        do
            c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(33, 126));
        while (c == CH_CR || c == CH_SPACE || c == CH_TAB);
        return c;
    endfunction

    function automatic logic [7:0] random_blank(input bit tabs);
        return (tabs && $urandom_range(0, 1)) ? CH_TAB : CH_SPACE;
    endfunction

    // Appends a run of trailing blanks; now and then one long enough to fill
    // or overflow the hold store.
    task automatic add_trailing(input bit tabs);
        int n;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(HELD_MAX - 1, HELD_MAX + 1)
                                        : $urandom_range(0, 2);
        repeat (n) block_bytes = {block_bytes, random_blank(tabs)};
    endtask

    // Builds a well-formed header block with random content.
    task automatic build_block();
        int fields;
        int n;
        block_bytes.delete();
        fields = $urandom_range(0, 2);
        repeat (fields)
        begin
            // Name with the odd inner space, then trailing spaces and the colon.
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0 && $urandom_range(0, 4) == 0)
                    block_bytes = {block_bytes, CH_SPACE};
                block_bytes = {block_bytes, random_token()};
            end
            add_trailing(1'b0);
            block_bytes = {block_bytes, CH_COLON};

            // Leading blanks, the value with inner blanks, trailing blanks.
            repeat ($urandom_range(0, 2)) block_bytes = {block_bytes, random_blank(1'b1)};
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0 && $urandom_range(0, 3) == 0)
                    block_bytes = {block_bytes, random_blank(1'b1)};
                block_bytes = {block_bytes, random_value_byte()};
            end
            add_trailing(1'b1);

            // Sometimes a continuation line.
            if ($urandom_range(0, 3) == 0)
            begin
                block_bytes = {block_bytes, CH_CR};
                block_bytes = {block_bytes, CH_LF};
                block_bytes = {block_bytes, random_blank(1'b1)};
                repeat ($urandom_range(1, 3)) block_bytes = {block_bytes, random_value_byte()};
                add_trailing(1'b1);
            end
            block_bytes = {block_bytes, CH_CR};
            block_bytes = {block_bytes, CH_LF};
        end
        block_bytes = {block_bytes, CH_CR};
        block_bytes = {block_bytes, CH_LF};
        // Bytes after completion are ignored up to the end of the buffer.
        if ($urandom_range(0, 4) == 0)
            block_bytes = {block_bytes, 8'($urandom_range(0, 255))};
    endtask

    // Pops results at random and hands every transaction to the checker.
    initial
    begin
        bit         took;
        logic [2:0] got_kind;
        logic [7:0] got_data;
        logic       got_last;
        pop <= 1'b0;
        forever
        begin
            @(negedge clk);
            took     = (pop === 1'b1) && (empty === 1'b0);
            got_kind = kind;
            got_data = data_byte;
            got_last = run_last;
            @(posedge clk);
            if (took)
                board.check_result(got_kind, got_data, got_last);
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Reset, directed bytes, random blocks, then the final verdict.
    initial
    begin
        int phase_now;
        int phase_next;
        int sel;
        int keep;
        board          = new();
        send_idle_pct  = SEND_IDLE[0];
        recv_stall_pct = RECV_STALL[0];
        live_items     = 0;
        rst_n      <= 1'b0;
        push       <= 1'b0;
        byte_value <= 8'h00;
        block_end  <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Empty block: CR LF straight away.
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b1);

        // Name with an inner space, dropped leading blanks, held blanks released
        // inside the value, a continuation line, a stray byte while waiting for
        // the final LF, and a byte ignored after completion.
        send_text("A b:", 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_text(" x ", 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_text("y", 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_text("z", 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_text("Q", 1'b0);
        send_byte(CH_LF, 1'b0);
        send_text("Z", 1'b1);

        // A byte outside the grammar on the last byte of the buffer.
        send_byte(CH_TILDE, 1'b0);
        send_byte(8'h80, 1'b1);

        // A buffer that ends in the middle of a name.
        send_byte(CH_PIPE, 1'b0);
        send_byte(CH_BANG, 1'b1);

        // Random blocks through the four traffic phases.
        live_items = 0;
        phase_now  = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            phase_next = live_items * 4 / RANDOM_ITEMS;
            if (phase_next > 3)
                phase_next = 3;
            if (phase_next != phase_now)
            begin
                drain_results();
                phase_now      = phase_next;
                send_idle_pct  = SEND_IDLE[phase_now];
                recv_stall_pct = RECV_STALL[phase_now];
            end

            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                // Pure noise.
                block_bytes.delete();
                repeat ($urandom_range(1, 6))
                    block_bytes = {block_bytes, 8'($urandom_range(0, 255))};
            end
            else
            begin
                build_block();
                if (sel <= 2)
                    block_bytes[$urandom_range(0, block_bytes.size() - 1)] =
                        8'($urandom_range(0, 255));
                else if (sel == 3)
                begin
                    // Buffer cut short.
                    keep = $urandom_range(1, block_bytes.size());
                    while (block_bytes.size() > keep)
                        void'(block_bytes.pop_back());
                end
            end

            for (int i = 0; i < block_bytes.size(); i++)
                send_byte(block_bytes[i], i == block_bytes.size() - 1);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
